// ----- rtl/dsvj_pkg.sv -----
// ----------------------------------------------------------------------------
// Damped spring vertex jiggle: shared definitions
// Sizes, register indexes and the item types of the vertex jiggle core.
// ----------------------------------------------------------------------------
package dsvj_pkg;

  // Size of the mesh and of the velocity store.
  localparam int VERTICES = 1024;
  localparam int VTX_W    = 10;
  localparam int ADDR_W   = $clog2(VERTICES);

  // Pipeline depth, and the stage whose item writes its velocity back.
  localparam int NSTG     = 8;
  localparam int WB_STG   = 4;

  // Gravity times mass, narrowed by 16 bits.
  localparam int PULL_W   = 41;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED   = 3'd0,
    CFG_STIFFNESS = 3'd1,
    CFG_DAMPING   = 3'd2,
    CFG_GRAVITY_X = 3'd3,
    CFG_GRAVITY_Y = 3'd4,
    CFG_MASS      = 3'd5,
    CFG_WEIGHT    = 3'd6
  } cfg_idx_t;

  // Input item: one mesh vertex.
  typedef struct packed {
    logic               func;
    logic [VTX_W-1:0]   vertex;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [23:0]        step_time;
    logic               skip;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [VTX_W-1:0]   vertex_out;
    logic signed [31:0] new_offset_x;
    logic signed [31:0] new_offset_y;
    logic               saturated;
  } out_t;

  // Coefficients shared by both axis datapaths.
  typedef struct packed {
    logic [17:0] stiffness;
    logic [17:0] damping;
    logic [17:0] weight;
  } axis_cfg_t;

endpackage

// ----- rtl/dsvj_vel_mem.sv -----
// ----------------------------------------------------------------------------
// Velocity store
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsvj_vel_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dsvj_axis.sv -----
// ----------------------------------------------------------------------------
// Vertex jiggle axis datapath
// Spring, damping and displacement arithmetic for one axis.
// ----------------------------------------------------------------------------
module dsvj_axis (
  input  logic                            clk,
  input  logic [dsvj_pkg::NSTG:1]         ld,
  input  dsvj_pkg::axis_cfg_t             cfg,
  input  logic signed [dsvj_pkg::PULL_W-1:0] pull,
  input  logic signed [31:0]              offset,
  input  logic signed [31:0]              vel_rd,
  input  logic [23:0]                     dt,
  input  logic                            active,
  output logic signed [31:0]              vel_new,
  output logic signed [31:0]              new_offset,
  output logic                            sat
);
  import dsvj_pkg::*;

  // True when a value does not fit in signed 32 bits.
  function automatic logic ovf32(input logic signed [45:0] x);
    ovf32 = !((&x[45:31]) || !(|x[45:31]));
  endfunction

  // Clamp to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [45:0] x);
    if (ovf32(x)) begin
      sat32 = x[45] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  logic signed [31:0] off_q [1:NSTG-1];
  logic signed [31:0] v2;
  logic signed [50:0] spr2;
  logic signed [42:0] sum3;
  logic signed [61:0] prod4;
  logic signed [31:0] v5;
  logic               fl5;
  logic signed [56:0] d6;
  logic               fl6;
  logic signed [59:0] p7;
  logic               fl7;

  logic signed [34:0] spring;
  logic signed [45:0] vt;
  logic               vflag;
  logic signed [40:0] d6s;
  logic signed [43:0] d7;
  logic signed [45:0] osum;

  // The incoming offset travels alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      off_q[1] <= offset;
    end
    for (int k = 2; k < NSTG; k++) begin
      if (ld[k]) begin
        off_q[k] <= off_q[k-1];
      end
    end
  end

  // Narrowed products, rounding toward minus infinity.
  always_comb begin
    spring  = $signed(spr2[50:16]);
    vt      = $signed(prod4[61:16]);
    vflag   = ovf32(vt);
    vel_new = sat32(vt);
    d6s     = $signed(d6[56:16]);
    d7      = $signed(p7[59:16]);
    osum    = 46'(off_q[NSTG-1]) + 46'(d7);
  end

  // Velocity update: spring product, sum, damping product, clamp.
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      v2   <= vel_rd;
      spr2 <= off_q[1] * $signed({1'b0, cfg.stiffness});
    end
    if (ld[3]) begin
      sum3 <= 43'(v2) + 43'(pull) - 43'(spring);
    end
    if (ld[4]) begin
      prod4 <= sum3 * $signed({1'b0, cfg.damping});
    end
    if (ld[5]) begin
      v5  <= vel_new;
      fl5 <= vflag;
    end
  end

  // Displacement: velocity times frame time, then times weight.
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      d6  <= v5 * $signed({1'b0, dt});
      fl6 <= fl5;
    end
    if (ld[7]) begin
      p7  <= d6s * $signed({1'b0, cfg.weight});
      fl7 <= fl6;
    end
  end

  // Result register: new offset, or the offset passed through.
  always_ff @(posedge clk) begin
    if (ld[8]) begin
      if (active) begin
        new_offset <= sat32(osum);
        sat        <= fl7 | ovf32(osum);
      end else begin
        new_offset <= off_q[NSTG-1];
        sat        <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/damped_spring_vertex_jiggle_core.sv -----
// ----------------------------------------------------------------------------
// Damped spring vertex jiggle core
// Keeps a velocity per mesh vertex and moves each vertex offset along it.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data, one result per item, in order.
// An item is taken at a clock edge with valid high and stall low.
// Each taken item passes through the stage registers to the result
// register, which drives out_valid. The pipeline takes one item per cycle
// unless in_stall is high; a vertex still in a stage before write-back
// holds in_stall until that item has written its velocity back.
// The velocity store is one RAM with one read and one write port. After
// reset the store is cleared at one entry per cycle, all VERTICES (1024)
// entries, with in_stall high; configuration writes are taken meanwhile.
// When out_stall is high the stages behind the result register keep
// filling bubbles and then in_stall rises; no item is lost. Registers are
// written through cfg_we/cfg_index/cfg_data while idle; that rule binds
// the user, and the core itself does not enforce it.
// ----------------------------------------------------------------------------
module damped_spring_vertex_jiggle_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dsvj_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dsvj_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [dsvj_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsvj_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dsvj_pkg::*;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [ADDR_W-1:0] addr;
    logic              act;
    logic              clr;
  } ctl_t;

  // Configuration registers.
  logic               enabled;
  logic signed [31:0] gravity_x;
  logic signed [31:0] gravity_y;
  logic [23:0]        mass;
  axis_cfg_t          acfg;

  logic signed [PULL_W-1:0] pull_x;
  logic signed [PULL_W-1:0] pull_y;
  logic signed [56:0]       gm_x;
  logic signed [56:0]       gm_y;

  // Pipeline control.
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] free;
  logic [NSTG:1]   ld;
  ctl_t            ctl_q [1:NSTG];
  logic [23:0]     dt_q  [1:5];
  logic            hazard;
  logic            in_range;

  // Clearing pass.
  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;

  // Velocity store ports.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [63:0]       mem_wdata;
  logic [63:0]       mem_rdata;

  logic signed [31:0] vx_new;
  logic signed [31:0] vy_new;
  logic signed [31:0] nox;
  logic signed [31:0] noy;
  logic               satx;
  logic               saty;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b1;
      acfg.stiffness <= '0;
      acfg.damping   <= 18'd65536;
      gravity_x      <= '0;
      gravity_y      <= '0;
      mass           <= 24'd65536;
      acfg.weight    <= 18'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLED:   enabled        <= cfg_data[0];
        CFG_STIFFNESS: acfg.stiffness <= cfg_data[17:0];
        CFG_DAMPING:   acfg.damping   <= cfg_data[17:0];
        CFG_GRAVITY_X: gravity_x      <= cfg_data;
        CFG_GRAVITY_Y: gravity_y      <= cfg_data;
        CFG_MASS:      mass           <= cfg_data[23:0];
        CFG_WEIGHT:    acfg.weight    <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Gravity times mass, worked out from the registers and shared by all items.
  always_comb begin
    gm_x = gravity_x * $signed({1'b0, mass});
    gm_y = gravity_y * $signed({1'b0, mass});
  end

  always_ff @(posedge clk) begin
    pull_x <= $signed(gm_x[56:16]);
    pull_y <= $signed(gm_y[56:16]);
  end

  // Stage handshake: a stage loads when it is empty or the stage after it has room.
  always_comb begin
    free[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
    hazard = 1'b0;
    for (int k = 1; k <= WB_STG; k++) begin
      if (vld[k] && ctl_q[k].vertex == in_data.vertex) begin
        hazard = 1'b1;
      end
    end
    in_stall = clearing || !free[1] || hazard;
    ld[1]    = in_valid && !in_stall;
    for (int k = 2; k <= NSTG; k++) begin
      ld[k] = vld[k-1] && free[k];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (free[k]) begin
          vld[k] <= ld[k];
        end
      end
    end
  end

  assign in_range = 32'(in_data.vertex) < VERTICES;

  // Control and frame time travel with each item.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ctl_q[1].vertex <= in_data.vertex;
      ctl_q[1].addr   <= ADDR_W'(in_data.vertex);
      ctl_q[1].act    <= in_range && !in_data.func && enabled && !in_data.skip;
      ctl_q[1].clr    <= in_range && in_data.func;
      dt_q[1]         <= in_data.step_time;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (ld[k]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (ld[k]) begin
        dt_q[k] <= dt_q[k-1];
      end
    end
  end

  // Clearing pass over the velocity store after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == ADDR_W'(VERTICES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Write-back as the item leaves the velocity stages.
  always_comb begin
    mem_we    = clearing || (ld[WB_STG+1] && (ctl_q[WB_STG].act || ctl_q[WB_STG].clr));
    mem_waddr = clearing ? clr_cnt : ctl_q[WB_STG].addr;
    mem_wdata = (clearing || ctl_q[WB_STG].clr) ? 64'd0 : {vy_new, vx_new};
  end

  dsvj_vel_mem #(
    .WIDTH (64),
    .DEPTH (VERTICES)
  ) u_vel (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .re      (ld[1]),
    .rd_addr (ADDR_W'(in_data.vertex)),
    .rd_data (mem_rdata)
  );

  dsvj_axis u_axis_x (
    .clk        (clk),
    .ld         (ld),
    .cfg        (acfg),
    .pull       (pull_x),
    .offset     (in_data.offset_x),
    .vel_rd     (mem_rdata[31:0]),
    .dt         (dt_q[5]),
    .active     (ctl_q[NSTG-1].act),
    .vel_new    (vx_new),
    .new_offset (nox),
    .sat        (satx)
  );

  dsvj_axis u_axis_y (
    .clk        (clk),
    .ld         (ld),
    .cfg        (acfg),
    .pull       (pull_y),
    .offset     (in_data.offset_y),
    .vel_rd     (mem_rdata[63:32]),
    .dt         (dt_q[5]),
    .active     (ctl_q[NSTG-1].act),
    .vel_new    (vy_new),
    .new_offset (noy),
    .sat        (saty)
  );

  // Result item.
  always_comb begin
    out_valid             = vld[NSTG];
    out_data.vertex_out   = ctl_q[NSTG].vertex;
    out_data.new_offset_x = nox;
    out_data.new_offset_y = noy;
    out_data.saturated    = satx | saty;
  end

`ifndef ASSERT_OFF
  // No item is taken while the store is being cleared.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("item accepted during clearing pass");

  // The pipeline is empty for the whole clearing pass.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> vld == '0)
    else $error("item in flight during clearing pass");

  // Items in stage 1 and in stage 2 or WB_STG never share a vertex.
  a_no_hazard_12: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && vld[2]) |-> ctl_q[1].vertex != ctl_q[2].vertex)
    else $error("same vertex twice before write-back");

  a_no_hazard_14: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && vld[WB_STG]) |-> ctl_q[1].vertex != ctl_q[WB_STG].vertex)
    else $error("same vertex twice before write-back");
`endif

endmodule

// ----- tb/damped_spring_vertex_jiggle_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring vertex jiggle core: regression bench
// Streams vertex items through the core under several register settings and
// random idling on both sides. Every result is compared field by field with
// a velocity-tracking predictor that mirrors the core's fixed-point maths.
// ----------------------------------------------------------------------------
module damped_spring_vertex_jiggle_core_tb;
  import dsvj_pkg::*;

  // Operation codes carried in the func field.
  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam int          CHUNK_ITEMS   = 192;
  localparam int          RANDOM_CHUNKS = 6;
  localparam int          HOT_VERTICES  = 8;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam longint      S32_MAX       = 64'sd2147483647;
  localparam longint      S32_MIN       = -64'sd2147483648;

  // Register set as the predictor sees it.
  typedef struct packed {
    logic               enabled;
    logic [17:0]        stiffness;
    logic [17:0]        damping;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic [23:0]        mass;
    logic [17:0]        weight;
  } jiggle_settings_t;

  localparam jiggle_settings_t RESET_SETTINGS = '{enabled: 1'b1, stiffness: 18'd0,
    damping: 18'h10000, gravity_x: 32'sd0, gravity_y: 32'sd0, mass: 24'h10000,
    weight: 18'h10000};
  localparam jiggle_settings_t MAX_SETTINGS = '{enabled: 1'b1, stiffness: 18'h3FFFF,
    damping: 18'h3FFFF, gravity_x: 32'sh7FFFFFFF, gravity_y: 32'sh80000000,
    mass: 24'hFFFFFF, weight: 18'h3FFFF};
  localparam jiggle_settings_t MIN_SETTINGS = '{enabled: 1'b1, stiffness: 18'd0,
    damping: 18'd0, gravity_x: 32'sh80000000, gravity_y: 32'sh80000000, mass: 24'd0,
    weight: 18'd0};
  localparam jiggle_settings_t TRIAL_SETTINGS = '{enabled: 1'b1, stiffness: 18'h08000,
    damping: 18'h0F000, gravity_x: 32'sh00010000, gravity_y: -32'sh00020000,
    mass: 24'h010000, weight: 18'h10000};

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  in_t            in_data;
  logic           out_valid;
  logic           out_stall = 1'b0;
  out_t           out_data;
  logic           cfg_we;
  logic [2:0]     cfg_index;
  logic [31:0]    cfg_data;

  jiggle_settings_t   settings;
  logic signed [31:0] vel_x [VERTICES];
  logic signed [31:0] vel_y [VERTICES];
  out_t               pending_results[$];
  int                 send_idle_pct;
  int                 stall_pct;
  int                 mismatch_count = 0;
  int unsigned        cycle_count = 0;

  damped_spring_vertex_jiggle_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to signed 32 bits, raising the flag when the value is cut.
  function automatic longint clamp32(input longint x, inout logic clamped);
    if (x > S32_MAX) begin
      clamped = 1'b1;
      return S32_MAX;
    end
    if (x < S32_MIN) begin
      clamped = 1'b1;
      return S32_MIN;
    end
    return x;
  endfunction

  // One axis of the spring: updates the velocity and returns the new offset.
  // Every product is narrowed by an arithmetic shift, which floors.
  function automatic logic signed [31:0] advance_axis(inout logic signed [31:0] vel,
      input logic signed [31:0] off, input logic signed [31:0] grav,
      input logic [23:0] dt, inout logic clamped);
    longint pull;
    longint spring;
    longint sum;
    longint v;
    longint d;
    longint moved;
    pull   = (longint'(grav) * longint'(settings.mass)) >>> 16;
    spring = (longint'(off) * longint'(settings.stiffness)) >>> 16;
    sum    = longint'(vel) + pull - spring;
    v      = clamp32((sum * longint'(settings.damping)) >>> 16, clamped);
    vel    = v[31:0];
    d      = (v * longint'(dt)) >>> 16;
    d      = (d * longint'(settings.weight)) >>> 16;
    moved  = clamp32(longint'(off) + d, clamped);
    return moved[31:0];
  endfunction

  // Expected result of one vertex item; advances the velocity store.
  function automatic out_t predict_result(input in_t item);
    out_t               r;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               clamped;
    clamped        = 1'b0;
    r.vertex_out   = item.vertex;
    r.new_offset_x = item.offset_x;
    r.new_offset_y = item.offset_y;
    if (int'(item.vertex) < VERTICES) begin
      if (item.func == FUNC_CLEAR) begin
        vel_x[item.vertex] = '0;
        vel_y[item.vertex] = '0;
      end else if (settings.enabled && !item.skip) begin
        vx = vel_x[item.vertex];
        vy = vel_y[item.vertex];
        r.new_offset_x = advance_axis(vx, item.offset_x, settings.gravity_x,
                                      item.step_time, clamped);
        r.new_offset_y = advance_axis(vy, item.offset_y, settings.gravity_y,
                                      item.step_time, clamped);
        vel_x[item.vertex] = vx;
        vel_y[item.vertex] = vy;
      end
    end
    r.saturated = clamped;
    return r;
  endfunction

  function automatic in_t vertex_item(input logic func, input int vtx, input int ox,
      input int oy, input int dt, input logic skip);
    in_t item;
    item.func      = func;
    item.vertex    = vtx[VTX_W-1:0];
    item.offset_x  = ox;
    item.offset_y  = oy;
    item.step_time = dt[23:0];
    item.skip      = skip;
    return item;
  endfunction

  // Mostly small offsets and frame times on a few busy vertices, so that
  // velocities build up and the same vertex meets itself in the pipeline.
  function automatic in_t random_vertex();
    in_t item;
    int  pick;
    item.func   = ($urandom_range(99) < 6) ? FUNC_CLEAR : FUNC_STEP;
    item.skip   = ($urandom_range(99) < 10);
    item.vertex = ($urandom_range(99) < 60) ? VTX_W'($urandom_range(HOT_VERTICES - 1))
                                             : VTX_W'($urandom_range(VERTICES - 1));
    item.offset_x = ($urandom_range(99) < 70) ? $urandom_range(0, 2**21) - 2**20
                                               : $urandom;
    item.offset_y = ($urandom_range(99) < 70) ? $urandom_range(0, 2**21) - 2**20
                                               : $urandom;
    pick = $urandom_range(99);
    if (pick < 70)
      item.step_time = 24'($urandom_range(0, 8192));
    else if (pick < 90)
      item.step_time = 24'($urandom);
    else
      item.step_time = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
    return item;
  endfunction

  // Plausible spring settings, with now and then every register but enabled at random.
  function automatic jiggle_settings_t random_settings();
    jiggle_settings_t s;
    s.enabled = 1'b1;
    if ($urandom_range(3) == 0) begin
      s.stiffness = 18'($urandom);
      s.damping   = 18'($urandom);
      s.gravity_x = $urandom;
      s.gravity_y = $urandom;
      s.mass      = 24'($urandom);
      s.weight    = 18'($urandom);
    end else begin
      s.stiffness = 18'($urandom_range(0, 32'h4000));
      s.damping   = 18'($urandom_range(32'hC000, 32'h10000));
      s.gravity_x = $urandom_range(0, 2**21) - 2**20;
      s.gravity_y = $urandom_range(0, 2**21) - 2**20;
      s.mass      = 24'($urandom_range(0, 32'h20000));
      s.weight    = 18'($urandom_range(0, 32'h18000));
    end
    return s;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes the whole register set; only called while the core is idle.
  task automatic apply_settings(input jiggle_settings_t s);
    write_reg(CFG_ENABLED,   {31'd0, s.enabled});
    write_reg(CFG_STIFFNESS, {14'd0, s.stiffness});
    write_reg(CFG_DAMPING,   {14'd0, s.damping});
    write_reg(CFG_GRAVITY_X, s.gravity_x);
    write_reg(CFG_GRAVITY_Y, s.gravity_y);
    write_reg(CFG_MASS,      {8'd0, s.mass});
    write_reg(CFG_WEIGHT,    {14'd0, s.weight});
    cfg_we   <= 1'b0;
    settings = s;
  endtask

  // Offers one item after a random gap and records its expected result
  // at the edge where the core takes it.
  task automatic send_vertex(input in_t item);
    out_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want            = predict_result(item);
    pending_results = {pending_results, want};
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register reset values: no pull and no gravity, so offsets pass unchanged.
  task automatic test_reset_defaults();
    send_vertex(vertex_item(FUNC_STEP, 3, 32'h00123456, -32'sh00654321, 24'h00FFFF, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 3, -32'sh00010000, 32'h7FFFFFFF, 24'hFFFFFF, 1'b0));
    wait_for_results();
  endtask

  // Clear requests, the disabled core and skipped vertices, and the velocity
  // being kept across them.
  task automatic test_pass_through();
    jiggle_settings_t s;
    s = TRIAL_SETTINGS;
    apply_settings(s);
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00030000, -32'sh00018000, 24'h000444, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00028000, -32'sh00010000, 24'h000444, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 7, 32'h00010000, 32'h00010000, 24'h001000, 1'b0));
    wait_for_results();
    s.enabled = 1'b0;
    apply_settings(s);
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00020000, 32'h00020000, 24'h000444, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00020000, 32'h00020000, 24'h000444, 1'b1));
    send_vertex(vertex_item(FUNC_CLEAR, 7, 32'h00040000, -32'sh00040000, 24'h000444, 1'b0));
    wait_for_results();
    s.enabled = 1'b1;
    apply_settings(s);
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00020000, 32'h00020000, 24'h000444, 1'b1));
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00020000, 32'h00020000, 24'h000444, 1'b0));
    send_vertex(vertex_item(FUNC_CLEAR, 5, 32'h00020000, 32'h00020000, 24'h000444, 1'b1));
    send_vertex(vertex_item(FUNC_STEP, 5, 32'h00020000, 32'h00020000, 24'h000444, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 7, 32'h00010000, 32'h00010000, 24'h001000, 1'b0));
    wait_for_results();
  endtask

  // Largest registers and field extremes, driving velocity and offset into
  // saturation, then a clear of the saturated vertex.
  task automatic test_field_extremes();
    apply_settings(MAX_SETTINGS);
    send_vertex(vertex_item(FUNC_STEP, 1023, 32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 0, 32'h00000000, 32'h00000000, 24'h000000, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 1023, 32'h80000000, 32'h7FFFFFFF, 24'hFFFFFF, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 0, -1, 1, 24'h000001, 1'b0));
    send_vertex(vertex_item(FUNC_CLEAR, 1023, 32'h12345678, 32'hEDCBA987, 24'hFFFFFF, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 1023, 32'h00000000, 32'h00000000, 24'h000000, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 1023, -1, -1, 24'hFFFFFF, 1'b0));
    send_vertex(vertex_item(FUNC_STEP, 512, 32'h55555555, 32'hAAAAAAAA, 24'hAAAAAA, 1'b0));
    wait_for_results();
  endtask

  // Random vertex stream in chunks, each under its own register set, each pair
  // under one idling pattern: receiver then sender idling heavier, then none at all.
  task automatic test_random_stream();
    jiggle_settings_t s;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case (chunk / 2)
        0: begin
          send_idle_pct = 32;
          stall_pct     = 49;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct     = 32;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      if (chunk == 0)
        s = MAX_SETTINGS;
      else if (chunk == 3)
        s = MIN_SETTINGS;
      else
        s = random_settings();
      apply_settings(s);
      repeat (CHUNK_ITEMS) send_vertex(random_vertex());
      wait_for_results();
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: check each taken item, then choose the next stall.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual vertex %0d", $time,
                   out_data.vertex_out);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("vertex_out", longint'(want.vertex_out),
                        longint'(out_data.vertex_out));
          compare_field("new_offset_x", longint'($signed(want.new_offset_x)),
                        longint'($signed(out_data.new_offset_x)));
          compare_field("new_offset_y", longint'($signed(want.new_offset_y)),
                        longint'($signed(out_data.new_offset_y)));
          compare_field("saturated", longint'(want.saturated),
                        longint'(out_data.saturated));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("damped_spring_vertex_jiggle_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ENABLED;
    cfg_data  <= '0;
    foreach (vel_x[i]) begin
      vel_x[i] = '0;
      vel_y[i] = '0;
    end
    settings      = RESET_SETTINGS;
    send_idle_pct = 32;
    stall_pct     = 49;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_pass_through();
    test_field_extremes();
    test_random_stream();

    if (pending_results.size() != 0) begin
      $display("%0t: %0d results still expected", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("damped_spring_vertex_jiggle_core regression: pass");
    else
      $display("damped_spring_vertex_jiggle_core regression: fail");
    $finish;
  end

endmodule

// ----- damped_spring_vertex_jiggle_core.f -----
rtl/dsvj_pkg.sv
rtl/dsvj_vel_mem.sv
rtl/dsvj_axis.sv
rtl/damped_spring_vertex_jiggle_core.sv
tb/damped_spring_vertex_jiggle_core_tb.sv
